// ----- sv/fqp_pkg.sv -----
// ---------------------------------------------------------------------------
// fqp_pkg
// Shared types and constants for the fair-queue finish-tag pick block.
// ---------------------------------------------------------------------------
package fqp_pkg;

  localparam int QueueDepthDef = 16;
  localparam int NumFlowsDef   = 8;
  localparam int CostRegs      = 8;
  localparam int TagW          = 40;
  localparam int CostW         = 16;
  localparam int HandleW       = 16;
  localparam int FlowW         = 3;
  localparam int CfgIdxW       = 3;
  localparam logic [CostW-1:0] CostReset = 16'd256;
  localparam logic [TagW-1:0]  TagMax    = {TagW{1'b1}};

  localparam logic       OpEnq  = 1'b0;
  localparam logic       OpPick = 1'b1;

  localparam logic [1:0] StEnq   = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StPick  = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // one queue entry as it travels along the row of cells
  typedef struct packed {
    logic               valid;
    logic [HandleW-1:0] handle;
    logic [FlowW-1:0]   flow;
  } entry_t;

  // scan token: best candidate seen so far, handed cell to cell
  typedef struct packed {
    logic            found;
    logic [TagW-1:0] tag;
    logic [5:0]      pos;
  } scan_t;

  // finish tag with saturation
  function automatic logic [TagW-1:0] calc_tag(input logic [TagW-1:0] vclk,
                                               input logic [TagW-1:0] last,
                                               input logic [CostW-1:0] cost);
    logic [TagW-1:0] start;
    logic [TagW:0]   sum;
    start = (vclk > last) ? vclk : last;
    sum   = {1'b0, start} + {{(TagW-CostW+1){1'b0}}, cost};
    return sum[TagW] ? TagMax : sum[TagW-1:0];
  endfunction

endpackage

// ----- sv/fair_queue_finish_tag_pick.sv -----
// ---------------------------------------------------------------------------
// fair_queue_finish_tag_pick
// Weighted fair dispatch queue: enqueue appends at the tail, dispatch picks
// the oldest entry with the smallest finish tag.
// ---------------------------------------------------------------------------
//  channel   handshake        payload
//  in        in_valid/stall   op, flow_id, handle
//  out       out_valid/stall  status, picked_handle, picked_flow,
//                             picked_finish_tag
//  cfg       cfg_valid/ready  cfg_index, cfg_data
//
//  An enqueue or a dispatch on an empty queue loads the result register at
//  the accepting edge. A dispatch on a non-empty queue scans first: the
//  registered scan token visits one cell per cycle, then the take state
//  removes the winner and closes the gap. Reset clears the valid bit of
//  every cell, the flow finish times and the virtual clock. The result
//  register holds while out_stall is high; in_stall stays high until the
//  block is back in idle with the result register free.
// ---------------------------------------------------------------------------
module fair_queue_finish_tag_pick
  import fqp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int NUM_FLOWS   = NumFlowsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [FlowW-1:0]   flow_id,
  input  logic [HandleW-1:0] handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [HandleW-1:0] picked_handle,
  output logic [FlowW-1:0]   picked_flow,
  output logic [TagW-1:0]    picked_finish_tag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CostW-1:0]   cfg_data
);

  localparam int PosW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FlowW-1:0] FlowLast = FlowW'(NUM_FLOWS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TAKE} state_t;

  state_t            state;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   step;
  logic [CostW-1:0]  cost [CostRegs];
  logic [TagW-1:0]   last_finish [NumFlowsDef];
  logic [TagW-1:0]   vclk;
  scan_t             best;

  entry_t            entries [QUEUE_DEPTH];
  scan_t             chain   [QUEUE_DEPTH];
  logic              load    [QUEUE_DEPTH];
  logic              shift   [QUEUE_DEPTH];
  entry_t            new_entry;
  logic              in_acc;
  logic              out_free;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;

  // result register loads this cycle
  assign out_load  = (state == S_TAKE) ||
                     ((state == S_IDLE) && in_acc && ((op == OpEnq) || (count == '0)));

  always_comb begin
    new_entry.valid  = 1'b1;
    new_entry.handle = handle;
    new_entry.flow   = (flow_id > FlowLast) ? FlowLast : flow_id;
  end

  // Every cell compares its own entry against the registered token "best";
  // only the output of the cell under scan is kept, so the token advances
  // one cell per cycle.
  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t right;
      assign right = (g == QUEUE_DEPTH-1) ? entry_t'('0) : entries[(g+1)%QUEUE_DEPTH];
      assign load[g]  = in_acc && (op == OpEnq) && (count == CntW'(g));
      assign shift[g] = (state == S_TAKE) && (CntW'(g) >= CntW'(best.pos));
      fqp_cell #(.PosW(PosW)) u_cell (
        .clk, .rst,
        .pos(PosW'(g)),
        .load(load[g]),
        .load_entry(new_entry),
        .shift(shift[g]),
        .right_entry(right),
        .scan_en(state == S_SCAN),
        .scan_in(best),
        .vclk,
        .last_finish,
        .cost,
        .entry(entries[g]),
        .scan_out(chain[g])
      );
    end
  endgenerate

  // token output of the cell under scan
  scan_t cur_out;
  always_comb begin
    cur_out = best;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (step == CntW'(i)) cur_out = chain[i];
    end
  end

  // picked entry at the winning position
  entry_t win;
  always_comb begin
    win = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (best.pos == 6'(i)) win = entries[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      vclk      <= '0;
      out_valid <= 1'b0;
      best      <= '0;
      for (int i = 0; i < CostRegs; i++) cost[i] <= CostReset;
      for (int i = 0; i < NumFlowsDef; i++) last_finish[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) cost[cfg_index] <= cfg_data;
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            picked_handle     <= '0;
            picked_flow       <= '0;
            picked_finish_tag <= '0;
            if (op == OpEnq) begin
              out_valid <= 1'b1;
              if (count == CntW'(QUEUE_DEPTH)) begin
                status <= StFull;
              end else begin
                status <= StEnq;
                count  <= count + 1'b1;
              end
            end else if (count == '0) begin
              out_valid <= 1'b1;
              status    <= StEmpty;
            end else begin
              best  <= '0;
              step  <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // advance the token one cell
          best <= cur_out;
          step <= step + 1'b1;
          if (step == count - 1'b1) state <= S_TAKE;
        end
        S_TAKE: begin
          // drop the winner, update flow and virtual time
          last_finish[win.flow] <= best.tag;
          if (best.tag > vclk) vclk <= best.tag;
          count             <= count - 1'b1;
          status            <= StPick;
          picked_handle     <= win.handle;
          picked_flow       <= win.flow;
          picked_finish_tag <= best.tag;
          out_valid         <= 1'b1;
          step              <= '0;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/fqp_cell.sv -----
// ---------------------------------------------------------------------------
// fqp_cell
// One queue slot. Holds an entry, compares the entry's tag against the
// registered scan token and passes the token on.
// ---------------------------------------------------------------------------
module fqp_cell
  import fqp_pkg::*;
#(
  parameter int PosW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [PosW-1:0]     pos,
  input  logic                load,
  input  entry_t              load_entry,
  input  logic                shift,
  input  entry_t              right_entry,
  input  logic                scan_en,
  input  scan_t               scan_in,
  input  logic [TagW-1:0]     vclk,
  input  logic [TagW-1:0]     last_finish [NumFlowsDef],
  input  logic [CostW-1:0]    cost [CostRegs],
  output entry_t              entry,
  output scan_t               scan_out
);

  logic [TagW-1:0] tag;

  assign tag = calc_tag(vclk, last_finish[entry.flow], cost[entry.flow]);

  always_comb begin
    scan_out = scan_in;
    if (scan_en && entry.valid && (!scan_in.found || tag < scan_in.tag)) begin
      scan_out.found = 1'b1;
      scan_out.tag   = tag;
      scan_out.pos   = 6'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- tb/fair_queue_finish_tag_pick_chk.sv -----
// ---------------------------------------------------------------------------
// fair_queue_finish_tag_pick_chk
// Watches the request, result and cost-write channels of the fair dispatch
// queue, keeps its own copy of the queue, flow finish times and virtual clock,
// predicts each result and compares it against the block's output.
// ---------------------------------------------------------------------------
module fair_queue_finish_tag_pick_chk
  import fqp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic [FlowW-1:0]   flow_id,
  input  logic [HandleW-1:0] handle,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [HandleW-1:0] picked_handle,
  input  logic [FlowW-1:0]   picked_flow,
  input  logic [TagW-1:0]    picked_finish_tag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CostW-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         status;
    logic [HandleW-1:0] handle;
    logic [FlowW-1:0]   flow;
    logic [TagW-1:0]    tag;
  } dispatch_res_t;

  dispatch_res_t    pending_res[$];
  logic [CostW-1:0] flow_cost[CostRegs];
  logic [HandleW-1:0] q_handle[$];
  logic [FlowW-1:0]   q_flow[$];
  logic [TagW-1:0]  last_finish[NumFlowsDef];
  logic [TagW-1:0]  vclock;

  function automatic logic [TagW-1:0] tag_of(logic [FlowW-1:0] f);
    logic [TagW-1:0] start;
    logic [TagW:0]   sum;
    start = (vclock > last_finish[f]) ? vclock : last_finish[f];
    sum = {1'b0, start} + {{(TagW-CostW+1){1'b0}}, flow_cost[f]};
    return sum[TagW] ? TagMax : sum[TagW-1:0];
  endfunction

  function automatic dispatch_res_t predict_dispatch(logic o, logic [FlowW-1:0] f,
                                                     logic [HandleW-1:0] h);
    dispatch_res_t r;
    int best;
    logic [TagW-1:0] best_tag, t;
    r = '0;
    if (o == OpEnq) begin
      if (q_handle.size() >= QueueDepthDef) begin
        r.status = StFull;
      end else begin
        q_handle = {q_handle, h};
        q_flow = {q_flow, f};
        r.status = StEnq;
      end
      return r;
    end
    if (q_handle.size() == 0) begin
      r.status = StEmpty;
      return r;
    end
    best = 0;
    best_tag = tag_of(q_flow[0]);
    for (int i = 1; i < q_handle.size(); i++) begin
      t = tag_of(q_flow[i]);
      if (t < best_tag) begin
        best_tag = t;
        best = i;
      end
    end
    r.status = StPick;
    r.handle = q_handle[best];
    r.flow = q_flow[best];
    r.tag = best_tag;
    q_handle.delete(best);
    q_flow.delete(best);
    last_finish[r.flow] = best_tag;
    if (best_tag > vclock) vclock = best_tag;
    return r;
  endfunction

  assign pending_count = pending_res.size();

  always @(posedge clk) begin
    dispatch_res_t want;
    if (rst) begin
      for (int i = 0; i < CostRegs; i++) flow_cost[i] = CostReset;
      for (int i = 0; i < NumFlowsDef; i++) last_finish[i] = '0;
      vclock = '0;
      q_handle.delete();
      q_flow.delete();
      pending_res.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) flow_cost[cfg_index] = cfg_data;
      if (out_valid && !out_stall) begin
        if (pending_res.size() == 0) begin
          $error("result with no prediction waiting, status %0d", status);
          fail_count++;
        end else begin
          want = pending_res.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (picked_handle !== want.handle) begin
            $error("picked_handle: expected %0h, actual %0h", want.handle, picked_handle);
            fail_count++;
          end
          if (picked_flow !== want.flow) begin
            $error("picked_flow: expected %0d, actual %0d", want.flow, picked_flow);
            fail_count++;
          end
          if (picked_finish_tag !== want.tag) begin
            $error("picked_finish_tag: expected %0h, actual %0h", want.tag,
                   picked_finish_tag);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_res = {pending_res, predict_dispatch(op, flow_id, handle)};
      end
    end
  end

endmodule

// ----- tb/fair_queue_finish_tag_pick_tb.sv -----
// ---------------------------------------------------------------------------
// fair_queue_finish_tag_pick_tb
// Drives enqueue and dispatch transactions and cost writes into the fair
// dispatch queue with random gaps and output stalls; the checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module fair_queue_finish_tag_pick_tb;
  import fqp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OpEnq;
  logic [FlowW-1:0]   flow_id = '0;
  logic [HandleW-1:0] handle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [HandleW-1:0] picked_handle;
  logic [FlowW-1:0]   picked_flow;
  logic [TagW-1:0]    picked_finish_tag;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CostW-1:0]   cfg_data = '0;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  bit                 rx_hold_free = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fair_queue_finish_tag_pick u_dut (.*);
  fair_queue_finish_tag_pick_chk u_chk (.*);

  // Gap length: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random, except during the free stretches.
  always @(posedge clk) begin
    if (rst || rx_hold_free) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one transaction after an optional gap; valid stays high after the
  // accepting edge until the next gap or drain drops it.
  task automatic send_txn(logic o, logic [FlowW-1:0] f, logic [HandleW-1:0] h);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    flow_id <= f;
    handle <= h;
    do @(posedge clk); while (in_stall);
  endtask

  // Every enqueue and dispatch gives a result, so draining the checker means idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_cost(logic [CfgIdxW-1:0] idx, logic [CostW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load all eight costs according to one of several profiles.
  task automatic set_costs(int profile);
    logic [CostW-1:0] v;
    for (int i = 0; i < CostRegs; i++) begin
      case (profile)
        0: v = CostReset;
        1: v = 16'hFFFF;
        2: v = 16'd1;
        3: v = (i % 2) ? 16'd1 : 16'hFFFF;
        default: v = 16'($urandom_range(1, 65535));
      endcase
      write_cost(i[CfgIdxW-1:0], v);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int prof;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dispatch, handle and flow extremes, ties, full queue.
    send_txn(OpPick, 3'd5, 16'hFFFF);
    send_txn(OpEnq, 3'd0, 16'h0000);
    send_txn(OpEnq, 3'd7, 16'hFFFF);
    send_txn(OpEnq, 3'd0, 16'hA5A5);
    send_txn(OpPick, 3'd0, 16'h0);
    send_txn(OpPick, 3'd0, 16'h0);
    send_txn(OpPick, 3'd0, 16'h0);
    send_txn(OpPick, 3'd0, 16'h0);
    for (int i = 0; i < 17; i++) send_txn(OpEnq, i[2:0], 16'(16'h5A00 + i));
    drain();

    // Dispatch with the largest cost, starting from the full queue.
    set_costs(1);
    for (int i = 0; i < 5; i++) send_txn(OpPick, 3'd0, 16'h0);
    drain();

    // Random phases under varying cost profiles.
    prof = 2;
    for (int phase = 0; phase < 11; phase++) begin
      set_costs(prof);
      prof = (prof == 4) ? 0 : prof + 1;
      rx_hold_free = (phase % 3 == 2);
      for (int n = 0; n < 50; n++) begin
        send_txn(($urandom_range(0, 99) < (phase % 2 ? 60 : 40)) ? OpPick : OpEnq,
                 3'($urandom_range(0, 7)), 16'($urandom));
      end
      // Pause the sender until the result side has caught up.
      drain();
    end
    rx_hold_free = 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
